// File: rtl/bcmp_pkg.sv
// Package of the barometer compensation block: types, register map and constants.
package bcmp_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned HALF_W    = 16;
  localparam int unsigned UT_W      = 16;
  localparam int unsigned UP_W      = 19;
  localparam int unsigned TEMP_W    = 16;
  localparam int unsigned PRESS_W   = 18;
  localparam int unsigned OSS_W     = 2;
  localparam int unsigned ADDR_W    = 5;

  // Register word indices, decoded from paddr[4:2]
  localparam logic [2:0] REG_AC1_AC2 = 3'd0;
  localparam logic [2:0] REG_AC3_AC4 = 3'd1;
  localparam logic [2:0] REG_AC5_AC6 = 3'd2;
  localparam logic [2:0] REG_B1_B2   = 3'd3;
  localparam logic [2:0] REG_MC_MD   = 3'd4;
  localparam logic [2:0] REG_OSS     = 3'd5;

  localparam logic [OSS_W-1:0]  OSS_RESET    = 2'd3;
  localparam logic [WORD_W-1:0] TEMP_OFFSET  = 32'd4000;
  localparam logic [WORD_W-1:0] HALF_SCALE   = 32'd32768;
  localparam logic [WORD_W-1:0] PRESS_SCALE  = 32'd50000;
  localparam logic [WORD_W-1:0] POLY_A       = 32'd3038;
  localparam logic [WORD_W-1:0] POLY_B_NEG   = 32'hFFFF_E343; // -7357
  localparam logic [WORD_W-1:0] POLY_C       = 32'd3791;
  localparam logic [WORD_W-1:0] SMOOTH_RESET = 32'd100000;
  localparam logic [WORD_W-1:0] PRESS_MAX    = 32'd262143;

  // Divider: bits retired per cycle and resulting step count
  localparam int unsigned DIV_RADIX_BITS = 2;
  localparam int unsigned DIV_STEPS      = WORD_W / DIV_RADIX_BITS;
  localparam int unsigned DIV_CNT_W      = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [WORD_W-1:0] ac1_ac2;
    logic [WORD_W-1:0] ac3_ac4;
    logic [WORD_W-1:0] ac5_ac6;
    logic [WORD_W-1:0] b1_b2;
    logic [WORD_W-1:0] mc_md;
    logic [OSS_W-1:0]  oss;
  } cal_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic                     divide_fault;
    logic [PRESS_W-1:0]       pressure_smoothed;
    logic [PRESS_W-1:0]       pressure_now;
    logic signed [TEMP_W-1:0] temperature;
  } res_t;

endpackage

// File: rtl/bcmp_cfg.sv
// Calibration and oversampling register file behind an APB-style port.
module bcmp_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bcmp_pkg::ADDR_W-1:0]  paddr,
  input  logic [bcmp_pkg::WORD_W-1:0]  pwdata,
  output logic [bcmp_pkg::WORD_W-1:0]  prdata,
  output logic                         pready,
  output bcmp_pkg::cal_t               cal_o
);

  bcmp_pkg::cal_t cal_q, cal_d;
  logic [2:0]     idx;
  logic           wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cal_o  = cal_q;

  always_comb begin
    cal_d = cal_q;
    if (wr_en) begin
      case (idx)
        bcmp_pkg::REG_AC1_AC2: cal_d.ac1_ac2 = pwdata;
        bcmp_pkg::REG_AC3_AC4: cal_d.ac3_ac4 = pwdata;
        bcmp_pkg::REG_AC5_AC6: cal_d.ac5_ac6 = pwdata;
        bcmp_pkg::REG_B1_B2:   cal_d.b1_b2   = pwdata;
        bcmp_pkg::REG_MC_MD:   cal_d.mc_md   = pwdata;
        bcmp_pkg::REG_OSS:     cal_d.oss     = pwdata[bcmp_pkg::OSS_W-1:0];
        default:               cal_d         = cal_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      bcmp_pkg::REG_AC1_AC2: prdata = cal_q.ac1_ac2;
      bcmp_pkg::REG_AC3_AC4: prdata = cal_q.ac3_ac4;
      bcmp_pkg::REG_AC5_AC6: prdata = cal_q.ac5_ac6;
      bcmp_pkg::REG_B1_B2:   prdata = cal_q.b1_b2;
      bcmp_pkg::REG_MC_MD:   prdata = cal_q.mc_md;
      bcmp_pkg::REG_OSS:     prdata = {{(bcmp_pkg::WORD_W-bcmp_pkg::OSS_W){1'b0}}, cal_q.oss};
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '{oss: bcmp_pkg::OSS_RESET, default: '0};
    end else begin
      cal_q <= cal_d;
    end
  end

endmodule

// File: rtl/bcmp_div.sv
// Shared unsigned 32-bit restoring divider, two quotient bits per cycle.
module bcmp_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bcmp_pkg::div_req_t req_i,
  output bcmp_pkg::div_rsp_t rsp_o
);

  logic [bcmp_pkg::WORD_W-1:0]    rem_q, rem_d;
  logic [bcmp_pkg::WORD_W-1:0]    quo_q, quo_d;
  logic [bcmp_pkg::WORD_W-1:0]    dvs_q;
  logic [bcmp_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                           busy_q;
  logic                           done_q;
  logic                           last_step;

  // Retire DIV_RADIX_BITS quotient bits: shift in, compare, subtract
  always_comb begin
    logic [bcmp_pkg::WORD_W:0] trial;
    rem_d = rem_q;
    quo_d = quo_q;
    for (int i = 0; i < bcmp_pkg::DIV_RADIX_BITS; i++) begin
      trial = {rem_d, quo_d[bcmp_pkg::WORD_W-1]};
      quo_d = {quo_d[bcmp_pkg::WORD_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        trial    = trial - {1'b0, dvs_q};
        quo_d[0] = 1'b1;
      end
      rem_d = trial[bcmp_pkg::WORD_W-1:0];
    end
  end

  assign last_step = busy_q && !req_i.start &&
                     (cnt_q == bcmp_pkg::DIV_CNT_W'(bcmp_pkg::DIV_STEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= last_step;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q  <= cnt_q + 1'b1;
        busy_q <= !last_step;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// File: rtl/bcmp_core.sv
// Compensation sequencer around one shared 32x32 multiplier and the divider.
module bcmp_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bcmp_pkg::cal_t                cal_i,
  input  logic                          in_valid_i,
  input  logic [bcmp_pkg::UT_W-1:0]     in_ut_i,
  input  logic [bcmp_pkg::UP_W-1:0]     in_up_i,
  output logic                          in_ready_o,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output bcmp_pkg::res_t                res_o,
  output bcmp_pkg::div_req_t            div_req_o,
  input  bcmp_pkg::div_rsp_t            div_rsp_i
);

  localparam int unsigned W = bcmp_pkg::WORD_W;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_T0   = 5'd1;
  localparam logic [4:0] S_T1   = 5'd2;
  localparam logic [4:0] S_TDIV = 5'd3;
  localparam logic [4:0] S_B6   = 5'd4;
  localparam logic [4:0] S_SQ   = 5'd5;
  localparam logic [4:0] S_X2   = 5'd6;
  localparam logic [4:0] S_X1   = 5'd7;
  localparam logic [4:0] S_C1   = 5'd8;
  localparam logic [4:0] S_C2   = 5'd9;
  localparam logic [4:0] S_B4   = 5'd10;
  localparam logic [4:0] S_B7   = 5'd11;
  localparam logic [4:0] S_PDIV = 5'd12;
  localparam logic [4:0] S_H1   = 5'd13;
  localparam logic [4:0] S_H2   = 5'd14;
  localparam logic [4:0] S_H3   = 5'd15;
  localparam logic [4:0] S_SM   = 5'd16;
  localparam logic [4:0] S_DONE = 5'd17;

  function automatic logic [W-1:0] sx16(input logic [15:0] h);
    return {{(W-16){h[15]}}, h};
  endfunction

  function automatic logic [W-1:0] asr(input logic [W-1:0] v, input int unsigned s);
    return W'($signed(v) >>> s);
  endfunction

  function automatic logic [W-1:0] neg(input logic [W-1:0] v);
    return W'(0) - v;
  endfunction

  function automatic logic [bcmp_pkg::PRESS_W-1:0] sat_press(input logic [W-1:0] v);
    if (v[W-1])                   return '0;
    else if (v > bcmp_pkg::PRESS_MAX) return bcmp_pkg::PRESS_W'(bcmp_pkg::PRESS_MAX);
    else                          return v[bcmp_pkg::PRESS_W-1:0];
  endfunction

  function automatic logic [bcmp_pkg::TEMP_W-1:0] sat_temp(input logic [W-1:0] v);
    if ($signed(v) < -32'sd32768)     return 16'h8000;
    else if ($signed(v) > 32'sd32767) return 16'h7FFF;
    else                              return v[bcmp_pkg::TEMP_W-1:0];
  endfunction

  logic [4:0]   state_q, state_d;
  logic [bcmp_pkg::UT_W-1:0] ut_q;
  logic [bcmp_pkg::UP_W-1:0] up_q;
  logic [W-1:0] prod_q, acc_q, b5_q, b6_q, sq_q, b3_q, b4_q, p_q, now_q, smooth_q;
  logic [bcmp_pkg::TEMP_W-1:0] temp_q;
  logic         fault_q, neg_q, dbl_q;

  logic [W-1:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  logic [W-1:0] mul_a, mul_b;
  logic [W-1:0] x1_t, d_t, n_t, x2_t, b6_c, x3_c, b3_v, b4_c, p_c, hp_c, now_c;
  logic [W-1:0] quo;

  assign ac1 = sx16(cal_i.ac1_ac2[31:16]);
  assign ac2 = sx16(cal_i.ac1_ac2[15:0]);
  assign ac3 = sx16(cal_i.ac3_ac4[31:16]);
  assign ac4 = {16'd0, cal_i.ac3_ac4[15:0]};
  assign ac5 = {16'd0, cal_i.ac5_ac6[31:16]};
  assign ac6 = {16'd0, cal_i.ac5_ac6[15:0]};
  assign b1  = sx16(cal_i.b1_b2[31:16]);
  assign b2  = sx16(cal_i.b1_b2[15:0]);
  assign mc  = sx16(cal_i.mc_md[31:16]);
  assign md  = sx16(cal_i.mc_md[15:0]);
  assign quo = div_rsp_i.quotient;

  always_comb begin
    logic [W-1:0] v;
    x1_t  = asr(prod_q, 15);
    d_t   = x1_t + md;
    n_t   = {mc[W-12:0], 11'd0};
    x2_t  = neg_q ? neg(quo) : quo;
    b6_c  = b5_q - bcmp_pkg::TEMP_OFFSET;
    x3_c  = asr(acc_q + asr(prod_q, 16) + 32'd2, 2);
    v     = ({ac1[W-3:0], 2'b00} + asr(prod_q, 11) + acc_q) << cal_i.oss;
    v     = v + 32'd2;
    // divide by four toward zero
    b3_v  = v[W-1] ? asr(v + 32'd3, 2) : (v >> 2);
    b4_c  = prod_q >> 15;
    p_c   = dbl_q ? {quo[W-2:0], 1'b0} : quo;
    hp_c  = asr(p_c, 8);
    now_c = p_q + asr(acc_q + asr(prod_q, 16) + bcmp_pkg::POLY_C, 4);
  end

  // Operand select for the shared multiplier; product is seen one state later
  always_comb begin
    case (state_q)
      S_T0:    begin mul_a = {16'd0, ut_q} - ac6; mul_b = ac5; end
      S_B6:    begin mul_a = b6_c;  mul_b = b6_c; end
      S_SQ:    begin mul_a = ac2;   mul_b = b6_q; end
      S_X2:    begin mul_a = b2;    mul_b = sq_q; end
      S_X1:    begin mul_a = ac3;   mul_b = b6_q; end
      S_C1:    begin mul_a = b1;    mul_b = sq_q; end
      S_C2:    begin mul_a = ac4;   mul_b = x3_c + bcmp_pkg::HALF_SCALE; end
      S_B4:    begin
        mul_a = {{(W-bcmp_pkg::UP_W){1'b0}}, up_q} - b3_q;
        mul_b = bcmp_pkg::PRESS_SCALE >> cal_i.oss;
      end
      S_PDIV:  begin mul_a = hp_c;   mul_b = hp_c; end
      S_H1:    begin mul_a = prod_q; mul_b = bcmp_pkg::POLY_A; end
      S_H2:    begin mul_a = bcmp_pkg::POLY_B_NEG; mul_b = p_q; end
      S_H3:    begin mul_a = smooth_q; mul_b = 32'd3; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    div_req_o.start    = 1'b0;
    div_req_o.dividend = '0;
    div_req_o.divisor  = b4_q;
    if (state_q == S_T1) begin
      div_req_o.start    = (d_t != '0);
      div_req_o.dividend = n_t[W-1] ? neg(n_t) : n_t;
      div_req_o.divisor  = d_t[W-1] ? neg(d_t) : d_t;
    end else if (state_q == S_B7) begin
      div_req_o.start    = 1'b1;
      div_req_o.dividend = prod_q[W-1] ? prod_q : {prod_q[W-2:0], 1'b0};
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_T0;
      S_T0:   state_d = S_T1;
      S_T1:   state_d = (d_t == '0) ? S_B6 : S_TDIV;
      S_TDIV: if (div_rsp_i.done) state_d = S_B6;
      S_B6:   state_d = fault_q ? S_DONE : S_SQ;
      S_SQ:   state_d = S_X2;
      S_X2:   state_d = S_X1;
      S_X1:   state_d = S_C1;
      S_C1:   state_d = S_C2;
      S_C2:   state_d = S_B4;
      S_B4:   state_d = (b4_c == '0) ? S_DONE : S_B7;
      S_B7:   state_d = S_PDIV;
      S_PDIV: if (div_rsp_i.done) state_d = S_H1;
      S_H1:   state_d = S_H2;
      S_H2:   state_d = S_H3;
      S_H3:   state_d = S_SM;
      S_SM:   state_d = S_DONE;
      S_DONE: if (res_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fault_q  <= 1'b0;
      smooth_q <= bcmp_pkg::SMOOTH_RESET;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: if (in_valid_i) fault_q <= 1'b0;
        S_T1:   if (d_t == '0) fault_q <= 1'b1;
        S_B4:   if (b4_c == '0) fault_q <= 1'b1;
        S_SM:   smooth_q <= asr(prod_q + now_q, 2);
        default: fault_q <= fault_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      S_IDLE: begin ut_q <= in_ut_i; up_q <= in_up_i; end
      S_T1:   begin
        acc_q <= x1_t;
        b5_q  <= x1_t;
        neg_q <= n_t[W-1] ^ d_t[W-1];
      end
      S_TDIV: if (div_rsp_i.done) b5_q <= acc_q + x2_t;
      S_B6:   begin
        b6_q   <= b6_c;
        temp_q <= sat_temp(asr(b5_q + 32'd8, 4));
      end
      S_SQ:   sq_q  <= asr(prod_q, 12);
      S_X2:   acc_q <= asr(prod_q, 11);
      S_X1:   b3_q  <= b3_v;
      S_C1:   acc_q <= asr(prod_q, 13);
      S_B4:   b4_q  <= b4_c;
      S_B7:   dbl_q <= prod_q[W-1];
      S_PDIV: if (div_rsp_i.done) p_q <= p_c;
      S_H2:   acc_q <= asr(prod_q, 16);
      S_H3:   now_q <= now_c;
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  assign res_o.temperature       = temp_q;
  assign res_o.divide_fault      = fault_q;
  assign res_o.pressure_now      = fault_q ? '0 : sat_press(now_q);
  assign res_o.pressure_smoothed = fault_q ? '0 : sat_press(smooth_q);

  a_smooth_only_in_sm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_SM) |=> $stable(smooth_q))
    else $error("smoothed pressure moved outside its update step");

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp_i.done |-> (state_q == S_TDIV || state_q == S_PDIV))
    else $error("divider finished while the sequencer was not waiting");

  a_fault_zero_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.divide_fault) |->
      (res_o.pressure_now == '0 && res_o.pressure_smoothed == '0))
    else $error("fault result carries nonzero pressure");

  a_start_to_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req_o.start |=> (state_q == S_TDIV || state_q == S_PDIV))
    else $error("divider started without a wait state following");

endmodule

// File: rtl/barometer_compensation.sv
// Top level of the barometer compensation block: streaming ports, APB registers, datapath.
//
// Usage: write the five calibration words and the oversampling setting over the
// APB-style port (word registers at byte addresses 0x00..0x14) while the block
// is idle. Each transfer on the slave stream carries one raw temperature and
// one aligned raw pressure; each produces exactly one transfer on the master
// stream with temperature (0.1 degC), instantaneous and smoothed pressure (Pa)
// and a divide fault flag in tuser.
// One item is in flight at a time: s_axis_tready drops for the whole
// computation. After the accepting edge the sequencer steps through its states
// around the shared multiplier and waits on the shared radix-4 divider for each
// of its two divisions (16 steps, then the done flag), then hands the result
// over. A new item is taken only once the sequencer is back in idle; an item
// that hits a zero divisor skips the rest of the sequence and finishes sooner.
// The result sits in an output register; the sequencer hands over and returns
// to idle, so a stalled receiver blocks only once a second result is ready.
// Reset clears the calibration words, sets oversampling to 3 and loads the
// smoothed pressure with 100000 Pa.
module barometer_compensation (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // slave stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [39:0]                  s_axis_tdata,  // raw_temperature[15:0], raw_pressure[34:16]
  // master stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [55:0]                  m_axis_tdata,  // temperature[15:0], pressure_now[33:16],
                                                      // pressure_smoothed[51:34]
  output logic [0:0]                   m_axis_tuser,  // divide_fault[0]
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bcmp_pkg::ADDR_W-1:0]  paddr,
  input  logic [bcmp_pkg::WORD_W-1:0]  pwdata,
  output logic [bcmp_pkg::WORD_W-1:0]  prdata,
  output logic                         pready
);

  bcmp_pkg::cal_t     cal;
  bcmp_pkg::div_req_t div_req;
  bcmp_pkg::div_rsp_t div_rsp;
  bcmp_pkg::res_t     res;
  logic               res_valid;
  logic               res_ready;

  logic               m_valid_q;
  logic [55:0]        m_data_q;
  logic               m_user_q;

  bcmp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cal_o   (cal)
  );

  bcmp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  bcmp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cal_i       (cal),
    .in_valid_i  (s_axis_tvalid),
    .in_ut_i     (s_axis_tdata[15:0]),
    .in_up_i     (s_axis_tdata[34:16]),
    .in_ready_o  (s_axis_tready),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp)
  );

  // Output register: load when empty or being drained this cycle
  assign res_ready = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_ready) begin
      m_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      m_data_q <= {4'd0, res.pressure_smoothed, res.pressure_now, res.temperature};
      m_user_q <= res.divide_fault;
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tuser[0] = m_user_q;

  // one item at a time: a transfer in closes the input until the result is handed on
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second item accepted while one is in progress");

endmodule

// File: tb/bcmp_checker.sv
// Checker for the barometer compensation block: predicts every reading, compares the results and checks read-back.
module bcmp_checker
  import bcmp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [39:0]         s_axis_tdata,   // raw_temperature[15:0], raw_pressure[34:16]
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [55:0]         m_axis_tdata,   // temperature[15:0], pressure_now[33:16],
                                              // pressure_smoothed[51:34]
  input  logic [0:0]          m_axis_tuser,   // divide_fault[0]
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [WORD_W-1:0]   pwdata,
  input  logic [WORD_W-1:0]   prdata,
  input  logic                pready,
  output int                  mismatch_count,
  output int                  pending_count,
  output int                  results_seen,
  output int                  faults_seen
);

  cal_t        cal;
  logic [31:0] smooth_acc;
  res_t        pending_readings[$];

  function automatic logic [31:0] sext16(input logic [15:0] h);
    return {{16{h[15]}}, h};
  endfunction

  function automatic logic [31:0] sra32(input logic [31:0] v, input int unsigned s);
    return $unsigned($signed(v) >>> s);
  endfunction

  // signed division, quotient truncated toward zero
  function automatic logic [31:0] div_trunc(input logic [31:0] n, input logic [31:0] d);
    logic [31:0] mn, mdv, q;
    mn  = n[31] ? 32'd0 - n : n;
    mdv = d[31] ? 32'd0 - d : d;
    q   = mn / mdv;
    return (n[31] ^ d[31]) ? 32'd0 - q : q;
  endfunction

  function automatic logic [PRESS_W-1:0] clamp_press(input logic [31:0] v);
    if (v[31]) return '0;
    return (v > PRESS_MAX) ? PRESS_MAX[PRESS_W-1:0] : v[PRESS_W-1:0];
  endfunction

  // Compensate one reading against the current calibration and, unless it faults, advance the smoother.
  task automatic compensate_sample(input logic [UT_W-1:0] ut_in, input logic [UP_W-1:0] up_in,
                                   output res_t r);
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut, up;
    logic [31:0] x1, x2, x3, dsr, b5, b6, sq, b3, b4, b7, p, hp, now, t, prod;
    logic [1:0]  oss;
    logic        fault;
    ac1 = sext16(cal.ac1_ac2[31:16]);
    ac2 = sext16(cal.ac1_ac2[15:0]);
    ac3 = sext16(cal.ac3_ac4[31:16]);
    ac4 = {16'd0, cal.ac3_ac4[15:0]};
    ac5 = {16'd0, cal.ac5_ac6[31:16]};
    ac6 = {16'd0, cal.ac5_ac6[15:0]};
    b1  = sext16(cal.b1_b2[31:16]);
    b2  = sext16(cal.b1_b2[15:0]);
    mc  = sext16(cal.mc_md[31:16]);
    md  = sext16(cal.mc_md[15:0]);
    oss = cal.oss;
    ut  = {16'd0, ut_in};
    up  = {13'd0, up_in};
    fault = 1'b0;

    prod = (ut - ac6) * ac5;
    x1   = sra32(prod, 15);
    dsr  = x1 + md;
    if (dsr == 32'd0) begin
      fault = 1'b1;
      x2    = 32'd0;
    end else begin
      x2 = div_trunc(mc << 11, dsr);
    end
    b5 = x1 + x2;
    t  = sra32(b5 + 32'd8, 4);
    if (t[31]) r.temperature = (t < 32'hFFFF_8000) ? 16'h8000 : t[15:0];
    else       r.temperature = (t > 32'h0000_7FFF) ? 16'h7FFF : t[15:0];

    b6   = b5 - TEMP_OFFSET;
    prod = b6 * b6;
    sq   = sra32(prod, 12);
    prod = b2 * sq;
    x1   = sra32(prod, 11);
    prod = ac2 * b6;
    x2   = sra32(prod, 11);
    x3   = x1 + x2;
    prod = ((ac1 * 32'd4 + x3) << oss) + 32'd2;
    b3   = div_trunc(prod, 32'd4);
    prod = ac3 * b6;
    x1   = sra32(prod, 13);
    prod = b1 * sq;
    x2   = sra32(prod, 16);
    x3   = sra32(x1 + x2 + 32'd2, 2);
    prod = ac4 * (x3 + HALF_SCALE);
    b4   = prod >> 15;
    if (b4 == 32'd0) fault = 1'b1;

    if (fault) begin
      // smoother holds its value on a fault
      r.pressure_now      = '0;
      r.pressure_smoothed = '0;
      r.divide_fault      = 1'b1;
    end else begin
      b7   = (up - b3) * (PRESS_SCALE >> oss);
      p    = b7[31] ? (b7 / b4) * 32'd2 : (b7 * 32'd2) / b4;
      hp   = sra32(p, 8);
      prod = hp * hp * POLY_A;
      x1   = sra32(prod, 16);
      prod = POLY_B_NEG * p;
      x2   = sra32(prod, 16);
      now  = p + sra32(x1 + x2 + POLY_C, 4);
      smooth_acc = sra32(smooth_acc * 32'd3 + now, 2);
      r.pressure_now      = clamp_press(now);
      r.pressure_smoothed = clamp_press(smooth_acc);
      r.divide_fault      = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t r;
    if (!rst_ni) begin
      cal            = '0;
      cal.oss        = OSS_RESET;
      smooth_acc     = SMOOTH_RESET;
      pending_readings.delete();
      mismatch_count = 0;
      pending_count  = 0;
      results_seen   = 0;
      faults_seen    = 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[4:2])
            REG_AC1_AC2: cal.ac1_ac2 = pwdata;
            REG_AC3_AC4: cal.ac3_ac4 = pwdata;
            REG_AC5_AC6: cal.ac5_ac6 = pwdata;
            REG_B1_B2:   cal.b1_b2   = pwdata;
            REG_MC_MD:   cal.mc_md   = pwdata;
            REG_OSS:     cal.oss     = pwdata[OSS_W-1:0];
            default: ;
          endcase
        end else begin
          case (paddr[4:2])
            REG_AC1_AC2: check_field("prdata cal_ac1_ac2", cal.ac1_ac2, prdata);
            REG_AC3_AC4: check_field("prdata cal_ac3_ac4", cal.ac3_ac4, prdata);
            REG_AC5_AC6: check_field("prdata cal_ac5_ac6", cal.ac5_ac6, prdata);
            REG_B1_B2:   check_field("prdata cal_b1_b2", cal.b1_b2, prdata);
            REG_MC_MD:   check_field("prdata cal_mc_md", cal.mc_md, prdata);
            REG_OSS:     check_field("prdata oversampling", {30'd0, cal.oss}, prdata);
            default: ;
          endcase
        end
      end

      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (m_axis_tuser[0] === 1'b1) faults_seen++;
        if (pending_readings.size() == 0) begin
          $error("result transfer with no reading outstanding");
          mismatch_count++;
        end else begin
          r = pending_readings.pop_front();
          check_field("temperature", {16'd0, r.temperature}, {16'd0, m_axis_tdata[15:0]});
          check_field("pressure_now", {14'd0, r.pressure_now}, {14'd0, m_axis_tdata[33:16]});
          check_field("pressure_smoothed", {14'd0, r.pressure_smoothed},
                      {14'd0, m_axis_tdata[51:34]});
          check_field("divide_fault", {31'd0, r.divide_fault}, {31'd0, m_axis_tuser[0]});
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        compensate_sample(s_axis_tdata[15:0], s_axis_tdata[34:16], r);
        pending_readings.push_back(r);
      end
      pending_count = pending_readings.size();
    end
  end

endmodule

// File: tb/tb.sv
// Testbench top for the barometer compensation block: stimulus, configuration and verdict.
module tb;
  import bcmp_pkg::*;

  // Spare word addresses beyond the register map; writes there must change nothing
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam int RANDOM_READINGS = 1950;
  localparam int HOLD_OFF_CYCLES = 400;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [39:0]        s_axis_tdata  = '0;   // raw_temperature[15:0], raw_pressure[34:16]
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [55:0]        m_axis_tdata;         // temperature[15:0], pressure_now[33:16],
                                            // pressure_smoothed[51:34]
  logic [0:0]         m_axis_tuser;         // divide_fault[0]
  logic               psel          = 1'b0;
  logic               penable       = 1'b0;
  logic               pwrite        = 1'b0;
  logic [ADDR_W-1:0]  paddr         = '0;
  logic [WORD_W-1:0]  pwdata        = '0;
  logic [WORD_W-1:0]  prdata;
  logic               pready;

  int mismatch_count, pending_count, results_seen, faults_seen;
  int  readings_sent = 0;
  int  cal_sets      = 0;
  int  stall_left    = 0;   // receiver hold-off still to run, in cycles
  bit  calm          = 1'b0; // suppress random idling on both sides

  barometer_compensation u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  bcmp_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .mismatch_count, .pending_count, .results_seen, .faults_seen
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Hold reset low from the start, then release it on a falling edge, once only
  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Receiver: drop tready about 30% of the time, or for a long counted hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 30);
      end
    end
  end

  // Abort far beyond the slowest legal run
  initial begin
    #2000000;
    $display("Timeout: result stream stalled");
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [31:0] pack_pair(input int hi, input int lo);
    logic [31:0] h, l;
    h = hi;
    l = lo;
    return {h[15:0], l[15:0]};
  endfunction

  function automatic int jitter(input int base, input int span);
    return base + int'($urandom_range(2 * span)) - span;
  endfunction

  // Coefficients near the datasheet set, each perturbed a little
  function automatic cal_t typical_cal();
    cal_t c;
    c.ac1_ac2 = pack_pair(jitter(408, 300), jitter(-72, 100));
    c.ac3_ac4 = pack_pair(jitter(-14383, 2000), jitter(32741, 1000));
    c.ac5_ac6 = pack_pair(jitter(32757, 1000), jitter(23153, 2000));
    c.b1_b2   = pack_pair(jitter(6190, 500), jitter(4, 20));
    c.mc_md   = pack_pair(jitter(-8711, 1000), jitter(2868, 500));
    c.oss     = OSS_W'($urandom_range(3));
    return c;
  endfunction

  function automatic cal_t datasheet_cal(input logic [OSS_W-1:0] oss);
    cal_t c;
    c.ac1_ac2 = pack_pair(408, -72);
    c.ac3_ac4 = pack_pair(-14383, 32741);
    c.ac5_ac6 = pack_pair(32757, 23153);
    c.b1_b2   = pack_pair(6190, 4);
    c.mc_md   = pack_pair(-8711, 2868);
    c.oss     = oss;
    return c;
  endfunction

  function automatic cal_t uniform_cal(input logic [31:0] word, input logic [OSS_W-1:0] oss);
    cal_t c;
    c.ac1_ac2 = word;
    c.ac3_ac4 = word;
    c.ac5_ac6 = word;
    c.b1_b2   = word;
    c.mc_md   = word;
    c.oss     = oss;
    return c;
  endfunction

  // One APB transfer: setup phase, access until pready, then an idle phase;
  // called on a falling edge
  task automatic apb_access(input logic wr, input logic [2:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  // Write every register, then read the whole map back for the checker
  task automatic load_calibration(input cal_t c);
    apb_access(1'b1, REG_AC1_AC2, c.ac1_ac2);
    apb_access(1'b1, REG_AC3_AC4, c.ac3_ac4);
    apb_access(1'b1, REG_AC5_AC6, c.ac5_ac6);
    apb_access(1'b1, REG_B1_B2, c.b1_b2);
    apb_access(1'b1, REG_MC_MD, c.mc_md);
    apb_access(1'b1, REG_OSS, {30'd0, c.oss});
    for (int r = REG_AC1_AC2; r <= REG_OSS; r++) apb_access(1'b0, r[2:0], '0);
    cal_sets++;
  endtask

  // Offer one reading, idling at random first; return on the falling edge after the transfer
  task automatic send_reading(input logic [UT_W-1:0] ut, input logic [UP_W-1:0] up);
    if (!calm) begin
      while ($urandom_range(99) < 30) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, up, ut};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    readings_sent++;
  endtask

  // Drop valid and wait until every outstanding reading has produced its result
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    cal_t            c;
    logic            typical;
    logic [OSS_W-1:0] oss;
    int              burst;
    int              phase;
    int              target;

    @(posedge rst_ni);
    @(negedge clk_i);

    // Reset calibration: read it back, then readings that must fault
    for (int r = REG_AC1_AC2; r <= REG_OSS; r++) apb_access(1'b0, r[2:0], '0);
    send_reading(16'd0, 19'd0);
    send_reading(16'hFFFF, 19'h7FFFF);
    drain();

    // Datasheet coefficients without oversampling, plus input extremes
    load_calibration(datasheet_cal(2'd0));
    send_reading(16'd27898, 19'd23843);
    send_reading(16'd0, 19'd0);
    send_reading(16'hFFFF, 19'h7FFFF);
    send_reading(16'd0, 19'h7FFFF);
    send_reading(16'hFFFF, 19'd0);
    drain();

    // Remaining oversampling settings
    for (int o = 1; o <= 3; o++) begin
      load_calibration(datasheet_cal(o[1:0]));
      send_reading(16'd27898, 19'(23843 << o));
      send_reading(16'd30000, 19'h7FFFF);
      drain();
    end

    // Temperature divisor zero: ac6 equal to the raw temperature and md zero
    c = datasheet_cal(2'd3);
    c.ac5_ac6[15:0] = 16'd27898;
    c.mc_md[15:0]   = 16'd0;
    load_calibration(c);
    send_reading(16'd27898, 19'd190744);
    send_reading(16'd28000, 19'd190744);
    drain();

    // Pressure divisor zero through ac4, then carry on: the smoother must have held
    c = datasheet_cal(2'd3);
    c.ac3_ac4[15:0] = 16'd0;
    load_calibration(c);
    send_reading(16'd27898, 19'd190744);
    drain();
    load_calibration(datasheet_cal(2'd3));
    send_reading(16'd27898, 19'd190744);
    drain();

    // Spare addresses are ignored; coefficient extremes follow
    apb_access(1'b1, REG_SPARE_LO, 32'hFFFF_FFFF);
    apb_access(1'b1, REG_SPARE_HI, 32'hFFFF_FFFF);
    load_calibration(uniform_cal(32'hFFFF_FFFF, 2'd3));
    send_reading(16'd0, 19'd0);
    send_reading(16'hFFFF, 19'h7FFFF);
    drain();
    load_calibration(uniform_cal(32'h7FFF_7FFF, 2'd0));
    send_reading(16'd0, 19'd0);
    send_reading(16'hFFFF, 19'h7FFFF);
    drain();
    load_calibration(uniform_cal(32'h8000_8000, 2'd3));
    send_reading(16'd0, 19'h7FFFF);
    send_reading(16'hFFFF, 19'd0);
    drain();

    // Random part: mostly plausible calibration and readings, the rest arbitrary words
    target = readings_sent + RANDOM_READINGS;
    phase  = 0;
    while (readings_sent < target) begin
      phase++;
      typical = ($urandom_range(99) < 75);
      if (typical) begin
        c = typical_cal();
      end else begin
        c.ac1_ac2 = $urandom;
        c.ac3_ac4 = $urandom;
        c.ac5_ac6 = $urandom;
        c.b1_b2   = $urandom;
        c.mc_md   = $urandom;
        c.oss     = OSS_W'($urandom_range(3));
      end
      load_calibration(c);
      oss   = c.oss;
      // a run of phases with no idling at all on either side
      calm  = (phase >= 8 && phase < 12);
      // one long receiver hold-off while readings keep coming, to back the block up
      if (phase == 4) stall_left = HOLD_OFF_CYCLES;
      burst = $urandom_range(30, 90);
      repeat (burst) begin
        if (typical && $urandom_range(99) < 85)
          send_reading(UT_W'($urandom_range(36000, 20000)),
                       UP_W'($urandom_range(40000, 15000) << oss));
        else
          send_reading(UT_W'($urandom), UP_W'($urandom));
      end
      drain();
    end
    calm = 1'b0;

    // Let any late result surface before the verdict
    while (pending_count != 0) @(negedge clk_i);
    repeat (64) @(negedge clk_i);

    $display("Run covered %0d readings over %0d calibration sets, %0d results, %0d divide faults,",
             readings_sent, cal_sets, results_seen, faults_seen);
    $display("with random idling, a calm stretch and a %0d-cycle output hold-off.",
             HOLD_OFF_CYCLES);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
